>>> rtl/saw_pkg.sv
// Shared types and constants for the stop-and-wait ARQ sender.
// Holds the item and result word structs, event codes and state encodings.
// No dependencies.
`timescale 1ns / 1ps

package saw_pkg;

  localparam int DATA_WIDTH_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int PKT_W           = 32;
  localparam int QCNT_W          = 5;

  // Event codes carried in func
  localparam logic [1:0] FUNC_NEW_PKT  = 2'd0;
  localparam logic [1:0] FUNC_TX_DONE  = 2'd1;
  localparam logic [1:0] FUNC_FEEDBACK = 2'd2;

  // Feedback frame kinds
  localparam logic [1:0] FB_ACK  = 2'd1;
  localparam logic [1:0] FB_NACK = 2'd2;

  // Encoded state as reported in the result word
  localparam logic [1:0] REP_IDLE    = 2'd0;
  localparam logic [1:0] REP_SENDING = 2'd1;
  localparam logic [1:0] REP_WAIT    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_SENDING = 3'b010,
    ST_WAIT    = 3'b100
  } sender_state_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [1:0]       frame_type;
    logic [PKT_W-1:0] packet_data;
  } item_t;

  typedef struct packed {
    logic              send_valid;
    logic [PKT_W-1:0]  send_data;
    logic [1:0]        fsm_state;
    logic [QCNT_W-1:0] queued_count;
    logic              overflow;
  } result_t;

endpackage

>>> rtl/stop_and_wait_arq_sender.sv
// Top level of the stop-and-wait ARQ sender: input register, core, result
// register. Depends on saw_pkg and saw_core.
//
// Usage:
//   item channel   (item_valid / item_ready / item): one event word per
//     handshake: new packet, transmit done, or feedback frame (ACK/NACK).
//   result channel (result_valid / result_ready / result): exactly one
//     result word per event: whether a packet goes on the link and which
//     word, the state after the event, the queue fill and a drop flag.
// Path: a word accepted is held in the input register, the core applies it
//   and its result is captured in the result register.
// Throughput: one event per cycle, sustained while results are taken. The
//   event is applied combinationally between the input register and the
//   result register; the queue is a RAM with registered read that is prefetched at the head.
// Reset (rst, synchronous): machine idle, no held packet, queue empty,
//   both registers empty. Queue RAM contents are not cleared.
// Receiver stall: the result register holds its word and the input
//   register takes one more event; after that item_ready drops until the
//   result is taken.
`timescale 1ns / 1ps

module stop_and_wait_arq_sender import saw_pkg::*; #(
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic    s1_valid;
  item_t   s1_item;
  logic    advance;
  result_t core_res;

  // Event leaves the input register when the result slot is free or freeing
  assign advance    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_item <= item;
    end
  end

  saw_core #(
    .DATA_WIDTH  (DATA_WIDTH),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (s1_item),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_res;
    end
  end

endmodule

>>> rtl/saw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module saw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/saw_core.sv
// Sender state machine, held packet and wait queue control.
// Depends on saw_pkg and saw_ram; one event is applied per step.
`timescale 1ns / 1ps

module saw_core import saw_pkg::*; #(
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  output result_t res
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sender_state_t          state, state_next;
  logic [DATA_WIDTH-1:0]  held, held_next;
  logic                   held_valid, held_valid_next;
  logic [PTR_W-1:0]       head, head_next, tail;
  logic [CNT_W-1:0]       count, count_next;
  logic [DATA_WIDTH-1:0]  head_byp;
  logic                   use_byp;
  logic [DATA_WIDTH-1:0]  ram_rd;
  logic [DATA_WIDTH-1:0]  head_data;
  logic [DATA_WIDTH-1:0]  word;
  logic [DATA_WIDTH-1:0]  sent;
  logic                   send, drop, push, pop, full, wr_en;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign word      = DATA_WIDTH'(item.packet_data);
  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign head_data = use_byp ? head_byp : ram_rd;

  always_comb begin
    state_next      = state;
    held_next       = held;
    held_valid_next = held_valid;
    send            = 1'b0;
    drop            = 1'b0;
    push            = 1'b0;
    pop             = 1'b0;
    sent            = held;
    case (item.func)
      FUNC_NEW_PKT: begin
        if (state == ST_IDLE) begin
          held_next       = word;
          held_valid_next = 1'b1;
          send            = 1'b1;
          sent            = word;
        end else if (!full) begin
          push = 1'b1;
        end else begin
          drop = 1'b1;
        end
      end
      FUNC_TX_DONE: state_next = ST_WAIT;
      FUNC_FEEDBACK: begin
        if (item.frame_type == FB_ACK) begin
          if (count == '0) begin
            state_next = ST_IDLE;
          end else begin
            pop             = 1'b1;
            held_next       = head_data;
            held_valid_next = 1'b1;
            send            = 1'b1;
            sent            = head_data;
          end
        end else if (item.frame_type == FB_NACK) begin
          send = held_valid;
        end
      end
      default: ;
    endcase
    if (send) begin
      state_next = ST_SENDING;
    end
  end

  always_comb begin
    count_next = count;
    if (push) begin
      count_next = count + 1'b1;
    end else if (pop) begin
      count_next = count - 1'b1;
    end
  end

  // RAM read address tracks the head after this step; registered read
  // then shows the new head next cycle.
  assign head_next = (step && pop) ? ptr_inc(head) : head;
  assign wr_en     = step && push;

  saw_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (word),
    .rd_addr (head_next),
    .rd_data (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      held_valid <= 1'b0;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      use_byp    <= 1'b0;
    end else begin
      // write landing on the address being read: forward it
      use_byp <= wr_en && (tail == head_next);
      if (step) begin
        state      <= state_next;
        held_valid <= held_valid_next;
        head       <= head_next;
        count      <= count_next;
        if (push) begin
          tail <= ptr_inc(tail);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (step) begin
      held <= held_next;
    end
    head_byp <= word;
  end

  always_comb begin
    res.send_valid   = send;
    res.send_data    = send ? PKT_W'(sent) : '0;
    res.queued_count = QCNT_W'(count_next);
    res.overflow     = drop;
    unique case (state_next)
      ST_IDLE:    res.fsm_state = REP_IDLE;
      ST_SENDING: res.fsm_state = REP_SENDING;
      ST_WAIT:    res.fsm_state = REP_WAIT;
      default:    res.fsm_state = REP_IDLE;
    endcase
  end

endmodule

>>> rtl/saw_checker.sv
// Port-level checks for the stop-and-wait ARQ sender, bound to the top.
// Depends on saw_pkg.
`timescale 1ns / 1ps

module saw_checker import saw_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_ready,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // nothing sent means a zero data word
  a_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.send_valid |-> result.send_data == '0)
    else $error("send_data nonzero without send_valid");

  // a send always leaves the machine in sending
  a_send_st: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.send_valid |-> result.fsm_state == REP_SENDING)
    else $error("send without sending state");

  // a drop only happens when busy, and never with a send
  a_drop: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.overflow |->
      !result.send_valid && result.fsm_state != REP_IDLE)
    else $error("overflow in idle or with a send");

  // input side only backs up behind a stalled result word
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid && !result_ready)
    else $error("item_ready low without a stalled result");

endmodule

bind stop_and_wait_arq_sender saw_checker u_saw_checker (.*);
